### src/cwig_pkg.sv
// Shared types, constants and instruction encoders for the CSR write instruction generator.
package cwig_pkg;

  localparam int unsigned REGION_WORDS = 1024;
  localparam int unsigned OFFSET_W = 11;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  localparam logic [6:0] OPC_SYSTEM  = 7'h73;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
  localparam logic [31:0] WORD_RET   = 32'h0000_8067;

  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_SRL    = 3'd5;
  localparam logic [2:0] F3_OR     = 3'd6;
  localparam logic [2:0] F3_CSRRW  = 3'd1;
  localparam logic [2:0] F3_CSRRWI = 3'd5;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_HIGH = 5'd3;
  localparam logic [4:0] REG_ACC  = 5'd4;
  localparam logic [4:0] REG_TMP  = 5'd28;

  localparam logic [11:0] SHIFT_32 = 12'd32;
  localparam logic [19:0] TMP_UPPER = 20'h00001;

  typedef struct packed {
    logic [11:0] csr;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        fits_imm;
    logic        hi_nz;
    logic        final_entry;
  } desc_t;

  typedef enum logic [4:0] {
    S_CSRWI,
    S_LUI_LO,
    S_ORI_LO,
    S_LUI_TMP_LO,
    S_ADDIW_LO,
    S_OR_LO,
    S_SLLI_LO,
    S_SRLI_LO,
    S_LUI_HI,
    S_ORI_HI,
    S_LUI_TMP_HI,
    S_ADDIW_HI,
    S_OR_HI,
    S_SLLI_HI,
    S_OR_ACC,
    S_CSRW,
    S_RET,
    S_DONE
  } step_t;

  function automatic logic [31:0] enc_lui(logic [4:0] rd, logic [31:0] half);
    return {half[31:12], rd, OPC_LUI};
  endfunction

  function automatic logic [31:0] enc_itype(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                            logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_or(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {7'd0, rs2, rs1, F3_OR, rd, OPC_OP};
  endfunction

  function automatic step_t first_step(desc_t d);
    return d.fits_imm ? S_CSRWI : S_LUI_LO;
  endfunction

  function automatic step_t next_step(step_t s, desc_t d);
    step_t n;
    n = S_DONE;
    case (s)
      S_CSRWI:      n = d.final_entry ? S_RET : S_DONE;
      S_LUI_LO:     n = d.lo[11] ? S_LUI_TMP_LO : S_ORI_LO;
      S_LUI_TMP_LO: n = S_ADDIW_LO;
      S_ADDIW_LO:   n = S_OR_LO;
      S_ORI_LO, S_OR_LO: begin
        if (d.lo[31]) n = S_SLLI_LO;
        else          n = d.hi_nz ? S_LUI_HI : S_CSRW;
      end
      S_SLLI_LO:    n = S_SRLI_LO;
      S_SRLI_LO:    n = d.hi_nz ? S_LUI_HI : S_CSRW;
      S_LUI_HI:     n = d.hi[11] ? S_LUI_TMP_HI : S_ORI_HI;
      S_LUI_TMP_HI: n = S_ADDIW_HI;
      S_ADDIW_HI:   n = S_OR_HI;
      S_ORI_HI, S_OR_HI: n = S_SLLI_HI;
      S_SLLI_HI:    n = S_OR_ACC;
      S_OR_ACC:     n = S_CSRW;
      S_CSRW:       n = d.final_entry ? S_RET : S_DONE;
      S_RET:        n = S_DONE;
      default:      n = S_DONE;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] enc_word(step_t s, desc_t d);
    logic [31:0] w;
    w = WORD_RET;
    case (s)
      S_CSRWI:      w = {d.csr, d.lo[4:0], F3_CSRRWI, REG_ZERO, OPC_SYSTEM};
      S_LUI_LO:     w = enc_lui(REG_ACC, d.lo);
      S_ORI_LO:     w = enc_itype(OPC_OPIMM, REG_ACC, F3_OR, REG_ACC, d.lo[11:0]);
      S_LUI_TMP_LO, S_LUI_TMP_HI: w = {TMP_UPPER, REG_TMP, OPC_LUI};
      S_ADDIW_LO:   w = enc_itype(OPC_OPIMM32, REG_TMP, F3_ADD, REG_TMP, d.lo[11:0]);
      S_OR_LO:      w = enc_or(REG_ACC, REG_TMP, REG_ACC);
      S_SLLI_LO:    w = enc_itype(OPC_OPIMM, REG_ACC, F3_SLL, REG_ACC, SHIFT_32);
      S_SRLI_LO:    w = enc_itype(OPC_OPIMM, REG_ACC, F3_SRL, REG_ACC, SHIFT_32);
      S_LUI_HI:     w = enc_lui(REG_HIGH, d.hi);
      S_ORI_HI:     w = enc_itype(OPC_OPIMM, REG_HIGH, F3_OR, REG_HIGH, d.hi[11:0]);
      S_ADDIW_HI:   w = enc_itype(OPC_OPIMM32, REG_TMP, F3_ADD, REG_TMP, d.hi[11:0]);
      S_OR_HI:      w = enc_or(REG_HIGH, REG_TMP, REG_HIGH);
      S_SLLI_HI:    w = enc_itype(OPC_OPIMM, REG_HIGH, F3_SLL, REG_HIGH, SHIFT_32);
      S_OR_ACC:     w = enc_or(REG_ACC, REG_HIGH, REG_ACC);
      S_CSRW:       w = {d.csr, REG_ACC, F3_CSRRW, REG_ZERO, OPC_SYSTEM};
      S_RET:        w = WORD_RET;
      default:      w = WORD_RET;
    endcase
    return w;
  endfunction

endpackage

### src/csr_write_instruction_generator_top.sv
// Top level of the CSR write instruction generator.
// Each request (CSR number, 64-bit value, final flag) turns into one to fourteen RV64
// instruction words, one result per word, each with its byte address program_base plus
// four times a running word offset that saturates at 2047 and is never cleared except by
// reset. The back end emits one word per cycle while out_ready allows, through a single
// result register, so that register sets the sustained rate of one word per cycle, with no
// gap between queued requests. A two-entry descriptor queue lets new requests be taken
// while earlier ones are still being emitted.
module csr_write_instruction_generator_top #(
  parameter int unsigned REGION_WORDS = cwig_pkg::REGION_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] csr_number,
  input  logic [63:0] csr_value,
  input  logic        final_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] word_address,
  output logic [31:0] instruction_word,
  output logic        last_of_run,
  output logic        region_overflow
);
  import cwig_pkg::*;

  logic [31:0] program_base;
  logic        push_valid;
  logic        push_ready;
  desc_t       push_desc;
  logic        q_valid;
  logic        q_pop;
  desc_t       q_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_base <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      program_base <= cfg_data;
    end
  end

  cwig_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .csr_number  (csr_number),
    .csr_value   (csr_value),
    .final_entry (final_entry),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_desc   (push_desc)
  );

  cwig_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_desc   (q_desc)
  );

  cwig_back #(
    .REGION_WORDS (REGION_WORDS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .program_base     (program_base),
    .q_valid          (q_valid),
    .q_desc           (q_desc),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .word_address     (word_address),
    .instruction_word (instruction_word),
    .last_of_run      (last_of_run),
    .region_overflow  (region_overflow)
  );

endmodule

### src/cwig_front.sv
// Front end: accepts a request and classifies its value into a sequence descriptor.
module cwig_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          csr_number,
  input  logic [63:0]          csr_value,
  input  logic                 final_entry,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cwig_pkg::desc_t      push_desc
);
  import cwig_pkg::*;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    push_desc.csr         = csr_number;
    push_desc.lo          = csr_value[31:0];
    push_desc.hi          = csr_value[63:32];
    push_desc.fits_imm    = (csr_value[63:5] == 59'd0);
    push_desc.hi_nz       = (csr_value[63:32] != 32'd0);
    push_desc.final_entry = final_entry;
  end

endmodule

### src/cwig_queue.sv
// Two-entry queue of sequence descriptors between the front and back ends.
module cwig_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cwig_pkg::desc_t push_desc,
  output logic            pop_valid,
  input  logic            pop,
  output cwig_pkg::desc_t pop_desc
);
  import cwig_pkg::*;

  desc_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_desc   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

### src/cwig_back.sv
// Back end: steps through the words of each descriptor and drives the result register.
module cwig_back #(
  parameter int unsigned REGION_WORDS = cwig_pkg::REGION_WORDS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     program_base,
  input  logic            q_valid,
  input  cwig_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     word_address,
  output logic [31:0]     instruction_word,
  output logic            last_of_run,
  output logic            region_overflow
);
  import cwig_pkg::*;

  logic                active;
  step_t               cur_step;
  step_t               step_now;
  step_t               step_after;
  logic [OFFSET_W-1:0] offset;
  logic                emit;
  logic                is_last;

  assign step_now   = active ? cur_step : first_step(q_desc);
  assign step_after = next_step(step_now, q_desc);
  assign is_last    = (step_after == S_DONE);
  assign emit       = q_valid && (!out_valid || out_ready);
  assign q_pop      = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cur_step  <= S_CSRWI;
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        active    <= !is_last;
        cur_step  <= step_after;
        if (offset != OFFSET_MAX) offset <= offset + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_address     <= program_base + {{(30-OFFSET_W){1'b0}}, offset, 2'b00};
      instruction_word <= enc_word(step_now, q_desc);
      last_of_run      <= is_last;
      region_overflow  <= ({{(32-OFFSET_W){1'b0}}, offset} >= REGION_WORDS[31:0])
                          || (offset == OFFSET_MAX);
    end
  end

  a_active_has_item: assert property (@(posedge clk) disable iff (rst)
    active |-> q_valid) else $error("sequence active without a queued descriptor");

  a_offset_saturates: assert property (@(posedge clk) disable iff (rst)
    (offset == OFFSET_MAX) |=> (offset == OFFSET_MAX)) else $error("word offset wrapped");

  a_continue_active: assert property (@(posedge clk) disable iff (rst)
    (emit && !is_last) |=> (active && q_valid))
    else $error("sequence dropped before its last word");

endmodule

### tb/sv/csr_word_checker.sv
// Checker that predicts every instruction word of the CSR write generator and compares results.
`timescale 1ns / 1ps
module csr_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] csr_number,
  input  logic [63:0] csr_value,
  input  logic        final_entry,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] word_address,
  input  logic [31:0] instruction_word,
  input  logic        last_of_run,
  input  logic        region_overflow,
  output int unsigned pending_words,
  output int unsigned failures
);
  import cwig_pkg::*;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] encoding;
    logic        last_word;
    logic        overflow;
  } program_word_t;

  logic [31:0]       base_addr;
  logic [10:0]       next_offset;
  program_word_t     expected_words[$];
  int unsigned       fail_count;

  initial begin
    pending_words = 0;
    failures = 0;
    fail_count = 0;
    base_addr = '0;
    next_offset = '0;
  end

  function automatic logic [31:0] u_type(logic [4:0] rd, logic [31:0] half);
    return {half[31:12], rd, OPC_LUI};
  endfunction

  function automatic logic [31:0] i_type(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] r_or(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {7'd0, rs2, rs1, F3_OR, rd, OPC_OP};
  endfunction

  // The word offset saturates at its top value, where every word is flagged.
  function automatic void emit_word(logic [31:0] encoding);
    program_word_t w;
    w.address = base_addr + {19'd0, next_offset, 2'b00};
    w.encoding = encoding;
    w.last_word = 1'b0;
    w.overflow = (next_offset >= REGION_WORDS) || (next_offset == OFFSET_MAX);
    expected_words = {expected_words, w};
    if (next_offset != OFFSET_MAX) next_offset = next_offset + 1'b1;
  endfunction

  function automatic void load_half(logic [4:0] rd, logic [31:0] half);
    emit_word(u_type(rd, half));
    if (!half[11]) begin
      emit_word(i_type(OPC_OPIMM, rd, F3_OR, rd, half[11:0]));
    end else begin
      emit_word(u_type(REG_TMP, 32'h0000_1000));
      emit_word(i_type(OPC_OPIMM32, REG_TMP, F3_ADD, REG_TMP, half[11:0]));
      emit_word(r_or(rd, REG_TMP, rd));
    end
  endfunction

  function automatic void predict_request(logic [11:0] csr, logic [63:0] value, logic fin);
    program_word_t w;
    if (value < 64'd32) begin
      emit_word({csr, value[4:0], F3_CSRRWI, REG_ZERO, OPC_SYSTEM});
    end else begin
      load_half(REG_ACC, value[31:0]);
      if (value[31]) begin
        emit_word(i_type(OPC_OPIMM, REG_ACC, F3_SLL, REG_ACC, SHIFT_32));
        emit_word(i_type(OPC_OPIMM, REG_ACC, F3_SRL, REG_ACC, SHIFT_32));
      end
      if (value[63:32] != 32'd0) begin
        load_half(REG_HIGH, value[63:32]);
        emit_word(i_type(OPC_OPIMM, REG_HIGH, F3_SLL, REG_HIGH, SHIFT_32));
        emit_word(r_or(REG_ACC, REG_HIGH, REG_ACC));
      end
      emit_word({csr, REG_ACC, F3_CSRRW, REG_ZERO, OPC_SYSTEM});
    end
    if (fin) emit_word(WORD_RET);
    w = expected_words.pop_back();
    w.last_word = 1'b1;
    expected_words = {expected_words, w};
  endfunction

  always @(posedge clk) begin
    program_word_t want;
    if (rst) begin
      base_addr = '0;
      next_offset = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: actual addr %h word %h last %b ovf %b",
                   $time, word_address, instruction_word, last_of_run, region_overflow);
        end else begin
          want = expected_words.pop_front();
          if (want.address !== word_address || want.encoding !== instruction_word ||
              want.last_word !== last_of_run || want.overflow !== region_overflow) begin
            fail_count++;
            $display("%0t: mismatch: expected %h %h %b %b, actual %h %h %b %b",
                     $time, want.address, want.encoding, want.last_word, want.overflow,
                     word_address, instruction_word, last_of_run, region_overflow);
          end
        end
      end
      if (cfg_valid && cfg_ready) base_addr = cfg_data;
      if (in_valid && in_ready) predict_request(csr_number, csr_value, final_entry);
    end
    pending_words <= expected_words.size();
    failures <= fail_count;
  end

endmodule

### tb/sv/tb.sv
// Testbench top: drives requests and base writes into the generator and reports the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_REQUESTS = 70;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] csr_number;
  logic [63:0] csr_value;
  logic        final_entry;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] word_address;
  logic [31:0] instruction_word;
  logic        last_of_run;
  logic        region_overflow;
  int unsigned pending_words;
  int unsigned failures;
  bit          quiet_phase;

  csr_write_instruction_generator_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .csr_number(csr_number),
    .csr_value(csr_value),
    .final_entry(final_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_address(word_address),
    .instruction_word(instruction_word),
    .last_of_run(last_of_run),
    .region_overflow(region_overflow)
  );

  csr_word_checker word_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .csr_number(csr_number),
    .csr_value(csr_value),
    .final_entry(final_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_address(word_address),
    .instruction_word(instruction_word),
    .last_of_run(last_of_run),
    .region_overflow(region_overflow),
    .pending_words(pending_words),
    .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid is only lowered here when a gap comes before the request, so back-to-back requests keep it high.
  task automatic send_request(input logic [11:0] csr, input logic [63:0] value,
                              input logic fin);
    int unsigned gap;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    csr_number <= csr;
    csr_value <= value;
    final_entry <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_request();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] value;
    int unsigned kind;
    lo = $urandom;
    hi = $urandom;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1:    value = 64'($urandom_range(0, 31));
      2:       value = {32'd0, lo};
      3:       value = {hi, 27'd0, lo[4:0]};
      4:       value = 64'($urandom_range(32, 63));
      default: value = {hi, lo};
    endcase
    send_request(12'($urandom_range(0, 4095)), value, $urandom_range(0, 3) == 0);
  endtask

  task automatic write_base(input logic [31:0] base);
    cfg_valid <= 1'b1;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int unsigned hold;
      int unsigned gap;
      if (quiet_phase) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        hold = $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (hold) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("csr_write_instruction_generator_top test failed");
    $finish;
  end

  initial begin
    logic [31:0] base;
    quiet_phase = 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    csr_number <= '0;
    csr_value <= '0;
    final_entry <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first requests run on the base left by reset.
    send_request(12'h000, 64'd0, 1'b0);
    send_request(12'hFFF, 64'd31, 1'b1);
    send_request(12'h305, 64'd32, 1'b0);
    send_request(12'h7FF, 64'h0000_0000_0000_07FF, 1'b0);
    wait_for_results();

    // A base at the top of the address space makes the word addresses wrap.
    write_base(32'hFFFF_FFFC);
    send_request(12'h800, 64'h0000_0000_0000_0800, 1'b1);
    send_request(12'h300, 64'h0000_0000_8000_0000, 1'b0);
    send_request(12'h341, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_request(12'h180, 64'h0000_0001_0000_0000, 1'b0);
    send_request(12'hABC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(12'h555, 64'h8000_0800_0000_0800, 1'b0);
    send_request(12'h0AA, 64'h0000_07FF_7FFF_F7FF, 1'b0);
    send_request(12'h001, 64'h7FFF_FFFF_0000_001F, 1'b1);
    send_request(12'hF0F, 64'h0000_0000_0000_0020, 1'b1);
    send_request(12'h123, 64'h0000_0000_0000_001F, 1'b0);
    send_request(12'h3A0, 64'h5555_5555_AAAA_AAAA, 1'b0);
    wait_for_results();

    // Each phase rewrites the base; the word offset keeps running until it saturates.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       base = 32'h0000_0000;
        2:       base = 32'hFFFF_FFFC;
        4:       base = 32'h0000_0003;
        default: base = $urandom_range(0, 32'hFFFF_FFFC);
      endcase
      write_base(base);
      quiet_phase = (phase == 1);
      repeat (PHASE_REQUESTS) send_random_request();
      wait_for_results();
    end
    quiet_phase = 1'b0;

    repeat (30) @(posedge clk);
    if (failures == 0 && pending_words == 0) begin
      $display("csr_write_instruction_generator_top test passed");
    end else begin
      $display("csr_write_instruction_generator_top test failed");
    end
    $finish;
  end

endmodule
